@@ rtl/assert_macros.svh @@
// Assertion macros included by binary_or_pool_2x2_unit, the one RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bop_pkg.sv @@
package bop_pkg;

    // Fixed field widths of the channels and registers.
    localparam int PIX_W  = 16;
    localparam int ADDR_W = 12;
    localparam int DIM_W  = 7;
    localparam int DST_W  = 11;

    // Default and fixed geometry.
    localparam int MAX_WIDTH_DEF = 64;
    localparam int WORD_BITS_DEF = 16;
    localparam int MAX_HEIGHT    = 64;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);

    // Register reset values.
    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 7'd12;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 7'd12;
    localparam logic [DST_W-1:0] DST_BASE_RST   = 11'd936;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_DST_BASE   = 2'd2
    } cfg_idx_t;

    // Position of the current item within the map.
    typedef struct packed {
        logic active;    // inside the even-sized part of the map
        logic col_odd;
        logic row_odd;
        logic last;      // last 2x2 block of the map
        logic map_end;   // last word of the map
    } pos_t;

endpackage

@@ rtl/bop_in_if.sv @@
interface bop_in_if;
    import bop_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink (input valid, input pixel_word, output ready);
endinterface

@@ rtl/bop_out_if.sv @@
interface bop_out_if;
    import bop_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pooled_word;
    logic [ADDR_W-1:0] dest_addr;
    logic              map_done;

    modport source (output valid, output pooled_word, output dest_addr, output map_done,
                    input ready);
    modport sink (input valid, input pooled_word, input dest_addr, input map_done,
                  output ready);
endinterface

@@ rtl/binary_or_pool_2x2_unit.sv @@
// A result is valid in the cycle after the item that completes its 2x2 block is taken.
// Throughput: one item per cycle; the single output register stalls the input only
// while it holds a result that the sink has not taken.
// The half-row line store is a RAM read every cycle at the column of the next item.
// Reset (rst_n, asynchronous, active low) clears counters, pair hold and output valid,
// and loads the registers with width 12, height 12 and base 936.
module binary_or_pool_2x2_unit #(
    parameter int MAX_WIDTH = bop_pkg::MAX_WIDTH_DEF,
    parameter int WORD_BITS = bop_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [bop_pkg::DST_W-1:0] cfg_data,
    bop_in_if.sink                    pix_in,
    bop_out_if.source                 pool_out
);
    import bop_pkg::*;
    `include "assert_macros.svh"

    localparam int HALF_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam logic [PIX_W-1:0] WORD_MASK =
        (WORD_BITS >= PIX_W) ? '1 : PIX_W'((64'd1 << WORD_BITS) - 64'd1);

    logic [DIM_W-1:0]  map_width_reg, map_height_reg;
    logic [DIM_W-1:0]  map_width_next;
    logic [DST_W-1:0]  dst_base_reg;
    logic [PIX_W-1:0]  pair_hold_reg, pair_hold_next;
    logic [ADDR_W-1:0] out_addr_run_reg, out_addr_run_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  pooled_reg, pooled_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic              done_reg, done_next;

    pos_t              pos;
    logic [IDX_W-1:0]  pair_idx, rd_idx;
    logic              accept, emit, wr_en;
    logic [PIX_W-1:0]  word, pair, store_rd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            dst_base_reg   <= DST_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[DIM_W-1:0];
                CFG_DST_BASE:   dst_base_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Width in force after this edge, for the line store read address.
    assign map_width_next = (cfg_we && (cfg_index == CFG_MAP_WIDTH)) ?
                            cfg_data[DIM_W-1:0] : map_width_reg;

    // Handshake: the output register frees as it is drained.
    assign pix_in.ready = !out_valid_reg || pool_out.ready;
    assign accept       = pix_in.valid && pix_in.ready;

    bop_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .IDX_W     (IDX_W)
    ) u_pos (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .map_width      (map_width_reg),
        .map_width_next (map_width_next),
        .map_height     (map_height_reg),
        .pos            (pos),
        .pair_idx       (pair_idx),
        .rd_idx         (rd_idx)
    );

    // Line store: write pair ORs on even rows; the read follows the next item's column.
    assign word  = pix_in.pixel_word & WORD_MASK;
    assign pair  = pair_hold_reg | word;
    assign wr_en = accept && pos.active && pos.col_odd && !pos.row_odd;
    assign emit  = accept && pos.active && pos.col_odd && pos.row_odd;

    bop_ram #(
        .WIDTH (PIX_W),
        .DEPTH (HALF_DEPTH),
        .AW    (IDX_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pair_idx),
        .wr_data (pair),
        .rd_en   (1'b1),
        .rd_addr (rd_idx),
        .rd_data (store_rd)
    );

    // Pair hold, address run and result register.
    always_comb
    begin
        pair_hold_next    = pair_hold_reg;
        out_addr_run_next = out_addr_run_reg;
        out_valid_next    = out_valid_reg && !pool_out.ready;
        pooled_next       = pooled_reg;
        dest_next         = dest_reg;
        done_next         = done_reg;
        if (accept && pos.active && !pos.col_odd)
        begin
            pair_hold_next = word;
        end
        if (emit)
        begin
            out_valid_next    = 1'b1;
            pooled_next       = store_rd | pair;
            dest_next         = ADDR_W'(dst_base_reg) + out_addr_run_reg;
            done_next         = pos.last;
            out_addr_run_next = out_addr_run_reg + ADDR_W'(1);
        end
        if (accept && pos.map_end)
        begin
            out_addr_run_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_hold_reg    <= '0;
            out_addr_run_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pair_hold_reg    <= pair_hold_next;
            out_addr_run_reg <= out_addr_run_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pooled_reg <= pooled_next;
        dest_reg   <= dest_next;
        done_reg   <= done_next;
    end

    assign pool_out.valid       = out_valid_reg;
    assign pool_out.pooled_word = pooled_reg;
    assign pool_out.dest_addr   = dest_reg;
    assign pool_out.map_done    = done_reg;

    // Checks on the pooling control.
    `ASSERT_SAME(a_emit_no_wr, clk, rst_n, emit, !wr_en,
                 "line store written by an item that completes a block")
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, emit, out_valid_reg,
                 "completed block did not raise output valid")
    `ASSERT_NEXT(a_run_clear, clk, rst_n, accept && pos.map_end, out_addr_run_reg == '0,
                 "address run not cleared at end of map")

endmodule

@@ rtl/bop_ram.sv @@
module bop_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read that holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bop_pos.sv @@
module bop_pos #(
    parameter int MAX_WIDTH = 64,
    parameter int IDX_W     = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [bop_pkg::DIM_W-1:0] map_width,
    input  logic [bop_pkg::DIM_W-1:0] map_width_next,
    input  logic [bop_pkg::DIM_W-1:0] map_height,
    output bop_pkg::pos_t             pos,
    output logic [IDX_W-1:0]          pair_idx,
    output logic [IDX_W-1:0]          rd_idx
);
    import bop_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int DW    = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;

    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [DW-1:0]    w, wp, cx, c;
    logic [DIM_W-1:0] h, hp, rx, r;
    logic [DW-1:0]    wn, cn, c_nx;

    // Clamp the configured dimensions and round down to even.
    always_comb
    begin
        if (DW'(map_width) < DW'(2))
            w = DW'(2);
        else if (DW'(map_width) > DW'(MAX_WIDTH))
            w = DW'(MAX_WIDTH);
        else
            w = DW'(map_width);

        if (map_height < DIM_W'(2))
            h = DIM_W'(2);
        else if (map_height > DIM_W'(MAX_HEIGHT))
            h = DIM_W'(MAX_HEIGHT);
        else
            h = map_height;

        wp = {w[DW-1:1], 1'b0};
        hp = {h[DIM_W-1:1], 1'b0};
    end

    // A counter at or past the last column or row counts as being at it.
    always_comb
    begin
        cx = DW'(col_count_reg);
        rx = DIM_W'(row_count_reg);
        c  = (cx < w) ? cx : w - DW'(1);
        r  = (rx < h) ? rx : h - DIM_W'(1);

        pos.active  = (c < wp) && (r < hp);
        pos.col_odd = c[0];
        pos.row_odd = r[0];
        pos.last    = (r == hp - DIM_W'(1)) && (c == wp - DW'(1));
        pos.map_end = (c >= w - DW'(1)) && (r >= h - DIM_W'(1));
        pair_idx    = IDX_W'(c >> 1);
    end

    // Raster-order advance on every accepted item.
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (advance)
        begin
            if (c >= w - DW'(1))
            begin
                col_count_next = '0;
                row_count_next = (r >= h - DIM_W'(1)) ? '0 : ROW_W'(r + DIM_W'(1));
            end
            else
            begin
                col_count_next = CNT_W'(c + DW'(1));
                row_count_next = ROW_W'(r);
            end
        end
    end

    // Line store slot of the column that the next item will see, with the width
    // that will be in force then.
    always_comb
    begin
        if (DW'(map_width_next) < DW'(2))
            wn = DW'(2);
        else if (DW'(map_width_next) > DW'(MAX_WIDTH))
            wn = DW'(MAX_WIDTH);
        else
            wn = DW'(map_width_next);

        cn     = DW'(col_count_next);
        c_nx   = (cn < wn) ? cn : wn - DW'(1);
        rd_idx = IDX_W'(c_nx >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

@@ tb/binary_or_pool_2x2_unit_test.sv @@
module binary_or_pool_2x2_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bop_pkg::*;

    localparam int HALF_DEPTH     = MAX_WIDTH_DEF / 2;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 120;
    localparam int SWEEP_ITEMS    = 128;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]  word;
        logic [ADDR_W-1:0] addr;
        logic              done;
    } pooled_t;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_ITEM,
        ROW_ITEM_TYPED
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t kind;
        logic [1:0] index;
        logic [15:0] value;
        pooled_t     result;
    } plan_row_t;

    // Directed stimulus. Typed rows carry the result that their item completes.
    localparam int PLAN_ROWS = 30;
    plan_row_t directed_plan [PLAN_ROWS] = '{
        // Smallest map at base zero: all ones in one corner, then single bits.
        '{ROW_CONFIG, CFG_MAP_WIDTH, 16'h0002, '0},
        '{ROW_CONFIG, CFG_MAP_HEIGHT, 16'h0002, '0},
        '{ROW_CONFIG, CFG_DST_BASE, 16'h0000, '0},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        '{ROW_ITEM, '0, 16'h0000, '0},
        '{ROW_ITEM, '0, 16'h0000, '0},
        '{ROW_ITEM_TYPED, '0, 16'h0000, '{16'hFFFF, 12'd0, 1'b1}},
        '{ROW_ITEM, '0, 16'h0001, '0},
        '{ROW_ITEM, '0, 16'h0100, '0},
        '{ROW_ITEM, '0, 16'h8000, '0},
        '{ROW_ITEM_TYPED, '0, 16'h0010, '{16'h8111, 12'd0, 1'b1}},
        // Odd 3x3 map at the top base: last column and last row are dropped.
        '{ROW_CONFIG, CFG_MAP_WIDTH, 16'h0783, '0},
        '{ROW_CONFIG, CFG_MAP_HEIGHT, 16'h0403, '0},
        '{ROW_CONFIG, CFG_DST_BASE, 16'h07FF, '0},
        '{ROW_ITEM, '0, 16'h0003, '0},
        '{ROW_ITEM, '0, 16'h0030, '0},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        '{ROW_ITEM, '0, 16'h0300, '0},
        '{ROW_ITEM_TYPED, '0, 16'h3000, '{16'h3333, 12'd2047, 1'b1}},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        '{ROW_ITEM, '0, 16'hFFFF, '0},
        // Width and height below the minimum are used as two.
        '{ROW_CONFIG, CFG_MAP_WIDTH, 16'h0000, '0},
        '{ROW_CONFIG, CFG_MAP_HEIGHT, 16'h0401, '0},
        '{ROW_CONFIG, CFG_DST_BASE, 16'h0005, '0},
        '{ROW_ITEM, '0, 16'hAAAA, '0},
        '{ROW_ITEM, '0, 16'h5555, '0},
        '{ROW_ITEM, '0, 16'h0000, '0},
        '{ROW_ITEM_TYPED, '0, 16'h0000, '{16'hFFFF, 12'd5, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [DST_W-1:0] cfg_data;

    bop_in_if pix ();
    bop_out_if pooled ();

    // Mirror of the block's registers and pooling state.
    logic [DIM_W-1:0]  cur_width;
    logic [DIM_W-1:0]  cur_height;
    logic [DST_W-1:0]  cur_base;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [PIX_W-1:0]  pair_hold;
    logic [PIX_W-1:0]  half_rows [HALF_DEPTH];
    logic [ADDR_W-1:0] addr_run;

    pooled_t pooled_due [$];

    int mismatches    = 0;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    binary_or_pool_2x2_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .pool_out  (pooled)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advances the pooling state by one word; returns 1 when a 2x2 block completes.
    function automatic bit or_pool_predict(input logic [PIX_W-1:0] w, output pooled_t res);
        int unsigned wd;
        int unsigned ht;
        int unsigned wd_even;
        int unsigned ht_even;
        int unsigned c;
        int unsigned r;
        int unsigned slot;
        logic [PIX_W-1:0] pair;
        bit emitted;

        wd = dim_in_use(cur_width, MAX_WIDTH_DEF);
        ht = dim_in_use(cur_height, MAX_HEIGHT);
        wd_even = wd & 32'hFFFF_FFFE;
        ht_even = ht & 32'hFFFF_FFFE;
        c = (col_pos < wd) ? col_pos : wd - 1;
        r = (row_pos < ht) ? row_pos : ht - 1;
        emitted = 1'b0;
        res = '0;

        if (c < wd_even && r < ht_even)
        begin
            if (c[0] == 1'b0)
            begin
                pair_hold = w;
            end
            else
            begin
                pair = pair_hold | w;
                slot = (c >> 1) % HALF_DEPTH;
                if (r[0] == 1'b0)
                begin
                    half_rows[slot] = pair;
                end
                else
                begin
                    res.word = half_rows[slot] | pair;
                    res.addr = cur_base + addr_run;
                    res.done = (r == ht_even - 1) && (c == wd_even - 1);
                    addr_run = addr_run + 1'b1;
                    emitted = 1'b1;
                end
            end
        end

        // Step to the next map position; the last word of the map starts over.
        if (c >= wd - 1)
        begin
            col_pos = 0;
            if (r >= ht - 1)
            begin
                row_pos = 0;
                addr_run = '0;
            end
            else
            begin
                row_pos = r + 1;
            end
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        return emitted;
    endfunction

    // Stops offering items and waits until every pooled result has been taken.
    task automatic wait_for_idle();
        pix.valid <= 1'b0;
        while (pooled_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [DST_W-1:0] data);
        wait_for_idle();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_MAP_WIDTH:  cur_width = data[DIM_W-1:0];
            CFG_MAP_HEIGHT: cur_height = data[DIM_W-1:0];
            CFG_DST_BASE:   cur_base = data;
            default: ;
        endcase
    endtask

    // Offers one word, at times after a random gap, and predicts its result once it is taken.
    task automatic send_word(input logic [PIX_W-1:0] w, input bit typed, input pooled_t typed_res);
        pooled_t res;
        bit emitted;

        if ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            pix.pixel_word <= PIX_W'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_word <= w;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        emitted = or_pool_predict(w, res);
        if (typed)
            pooled_due.push_back(typed_res);
        else if (emitted)
            pooled_due.push_back(res);
    endtask

    // Result side: compare each taken result, then choose the next ready.
    always @(posedge clk)
    begin : take_pooled
        pooled_t got;
        pooled_t want;

        if (rst_n)
        begin
            if (pooled.valid && pooled.ready)
            begin
                got = '{pooled.pooled_word, pooled.dest_addr, pooled.map_done};
                if (pooled_due.size() == 0)
                begin
                    $error("unexpected pooled item: word %h addr %0d done %b",
                           got.word, got.addr, got.done);
                    mismatches++;
                end
                else
                begin
                    want = pooled_due.pop_front();
                    if (got.word !== want.word)
                    begin
                        $error("pooled_word: expected %h, got %h", want.word, got.word);
                        mismatches++;
                    end
                    if (got.addr !== want.addr)
                    begin
                        $error("dest_addr: expected %0d, got %0d", want.addr, got.addr);
                        mismatches++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("map_done: expected %b, got %b", want.done, got.done);
                        mismatches++;
                    end
                end
            end

            // A long hold-off fills the block so that it stalls its input.
            if (hold_left > 0)
            begin
                hold_left--;
                pooled.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                pooled.ready <= 1'b0;
            end
            else
            begin
                pooled.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
        else
        begin
            pooled.ready <= 1'b0;
        end
    end

    // Ends the run when neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix.valid && pix.ready) || (pooled.valid && pooled.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("binary_or_pool_2x2_unit_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase_sent;
        int unsigned wd_pick;
        int unsigned ht_pick;
        logic [DST_W-1:0] base_pick;
        logic [PIX_W-1:0] word;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MAP_WIDTH;
        cfg_data <= '0;
        pix.valid <= 1'b0;
        pix.pixel_word <= '0;

        cur_width = MAP_WIDTH_RST;
        cur_height = MAP_HEIGHT_RST;
        cur_base = DST_BASE_RST;
        col_pos = 0;
        row_pos = 0;
        pair_hold = '0;
        addr_run = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        foreach (directed_plan[i])
        begin
            case (directed_plan[i].kind)
                ROW_CONFIG:
                    write_reg(directed_plan[i].index, directed_plan[i].value[DST_W-1:0]);
                ROW_ITEM:
                    send_word(directed_plan[i].value, 1'b0, '0);
                default:
                    send_word(directed_plan[i].value, 1'b1, directed_plan[i].result);
            endcase
        end

        // Widest map (width above the maximum) fills every line store entry,
        // then the tallest map at the narrowest width.
        write_reg(CFG_MAP_WIDTH, 11'h07F);
        write_reg(CFG_MAP_HEIGHT, 11'h782);
        write_reg(CFG_DST_BASE, 11'h400);
        repeat (SWEEP_ITEMS) send_word(PIX_W'($urandom), 1'b0, '0);
        write_reg(CFG_MAP_WIDTH, 11'h002);
        write_reg(CFG_MAP_HEIGHT, 11'h040);
        repeat (SWEEP_ITEMS) send_word(PIX_W'($urandom), 1'b0, '0);

        // Random part, one phase per idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct <= 51;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    sink_stall_pct <= 51;
                end
                default:
                begin
                    send_idle_pct <= 26;
                    sink_stall_pct <= 26;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                if (col_pos == 0 && row_pos == 0 && $urandom_range(2) == 0)
                begin
                    // New geometry at a map boundary; large sizes stay rare and short.
                    case ($urandom_range(9))
                        0:
                        begin
                            case ($urandom_range(2))
                                0: wd_pick = 0;
                                1: wd_pick = 1;
                                default: wd_pick = $urandom_range(127, 65);
                            endcase
                            ht_pick = $urandom_range(4, 2);
                        end
                        1:
                        begin
                            case ($urandom_range(2))
                                0: ht_pick = 0;
                                1: ht_pick = 1;
                                default: ht_pick = $urandom_range(127, 65);
                            endcase
                            wd_pick = $urandom_range(4, 2);
                        end
                        2:
                        begin
                            wd_pick = $urandom_range(64, 63);
                            ht_pick = $urandom_range(3, 2);
                        end
                        default:
                        begin
                            wd_pick = $urandom_range(12, 2);
                            ht_pick = $urandom_range(12, 2);
                        end
                    endcase
                    case ($urandom_range(7))
                        0: base_pick = '0;
                        1: base_pick = '1;
                        default: base_pick = DST_W'($urandom);
                    endcase
                    write_reg(CFG_MAP_WIDTH, (DST_W'($urandom) & 11'h780) | DST_W'(wd_pick));
                    write_reg(CFG_MAP_HEIGHT, (DST_W'($urandom) & 11'h780) | DST_W'(ht_pick));
                    write_reg(CFG_DST_BASE, base_pick);
                end
                else if ($urandom_range(79) == 0)
                begin
                    // Change a register in the middle of a map; the line store is
                    // fully written by now, so every read has a known value.
                    case ($urandom_range(2))
                        0: write_reg(CFG_MAP_WIDTH, DST_W'($urandom_range(12, 2)));
                        1: write_reg(CFG_MAP_HEIGHT, DST_W'($urandom_range(12, 2)));
                        default: write_reg(CFG_DST_BASE, DST_W'($urandom));
                    endcase
                end

                if (phase == 0 && phase_sent == 40)
                    hold_requests <= hold_requests + 1;
                if (phase == 1 && phase_sent == 60)
                    wait_for_idle();
                if (phase == 2 && phase_sent == 0)
                    write_reg(CFG_SPARE, DST_W'($urandom));

                case ($urandom_range(7))
                    0: word = PIX_W'($urandom & $urandom & $urandom);
                    1: word = ($urandom_range(1) == 0) ? '0 : '1;
                    default: word = PIX_W'($urandom);
                endcase
                send_word(word, 1'b0, '0);
                phase_sent++;
            end
        end

        wait_for_idle();
        if (mismatches == 0 && pooled_due.size() == 0)
            $display("binary_or_pool_2x2_unit_test: PASS");
        else
            $display("binary_or_pool_2x2_unit_test: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bop_pkg.sv
rtl/bop_in_if.sv
rtl/bop_out_if.sv
rtl/bop_ram.sv
rtl/bop_pos.sv
rtl/binary_or_pool_2x2_unit.sv
tb/binary_or_pool_2x2_unit_test.sv
